// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the circumcentre block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define CC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked property, checked in reset too.
`define CC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== rtl/core/cc3d_pkg.sv =====
// ----------------------------------------------------------------------------
// cc3d_pkg
// Shared types and constants of the 3D circumcentre pipeline.
// ----------------------------------------------------------------------------
package cc3d_pkg;

  localparam int unsigned QBITS = 32;

  localparam logic [QBITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QBITS-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] big;
    logic       degen;
  } side_t;

endpackage

// ===== rtl/core/cc3d_div.sv =====
// ----------------------------------------------------------------------------
// cc3d_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cc3d_div #(
  parameter int unsigned RW = 102,
  parameter int unsigned DW = 70
) (
  input  logic                        clk_i,
  input  logic [cc3d_pkg::QBITS-1:0]  en_i,
  input  logic [RW-1:0]               rem_i,
  input  logic [DW-1:0]               den_i,
  output logic [cc3d_pkg::QBITS-1:0]  quo_o
);
  import cc3d_pkg::*;

  logic [RW-1:0]    r_q [QBITS];
  logic [RW-1:0]    r_d [QBITS];
  logic [DW-1:0]    d_q [QBITS];
  logic [DW-1:0]    d_d [QBITS];
  logic [QBITS-1:0] q_q [QBITS];
  logic [QBITS-1:0] q_d [QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    logic [RW-1:0]    rin;
    logic [DW-1:0]    din;
    logic [QBITS-1:0] qin;
    logic [RW-1:0]    dsh;

    if (i == 0) begin : g_first
      assign rin = rem_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = r_q[i-1];
      assign din = d_q[i-1];
      assign qin = q_q[i-1];
    end

    assign dsh = RW'(din) << (QBITS - 1 - i);

    always_comb begin
      d_d[i] = din;
      q_d[i] = qin;
      r_d[i] = rin;
      if (rin >= dsh) begin
        r_d[i] = rin - dsh;
        q_d[i][QBITS-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        r_q[i] <= r_d[i];
        d_q[i] <= d_d[i];
        q_q[i] <= q_d[i];
      end
    end
  end

  assign quo_o = q_q[QBITS-1];

endmodule

// ===== rtl/core/circumcenter_3d_points.sv =====
// ----------------------------------------------------------------------------
// circumcenter_3d_points
// Circumcentre of three 3D points, exact integer arithmetic, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel s_axis: one item is a triple of points, nine signed
// coordinates. Output channel m_axis: the centre as three signed 32-bit
// words, with degenerate and overflow flags in tuser.
// Throughput: one item per cycle unless the receiver stalls. The pipe holds
// 41 register stages: eight arithmetic stages (a subtract, a split
// multiply, a wide sum or the sign and range step per stage), 32 divider
// stages (one quotient bit each) and the saturating output register.
// Each stage holds its item until the next stage is free, so bubbles are
// squeezed out and a stalled receiver backs up the pipe without loss.
// Reset empties the pipe; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circumcenter_3d_points #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // center_x, center_y, center_z
  output logic [3*cc3d_pkg::QBITS-1:0]           m_axis_tdata,
  // degenerate, overflow
  output logic [1:0]                             m_axis_tuser
);
  import cc3d_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned UW = CW + 1;
  localparam int unsigned NW = 2*CW + 3;
  localparam int unsigned XW = 3*CW + 4;
  localparam int unsigned DW = 4*CW + 6;
  localparam int unsigned MW = 5*CW + 8;
  localparam int unsigned HX = XW / 2;
  localparam int unsigned HD = DW / 2;
  localparam int unsigned RW = DW + QBITS;
  localparam int unsigned LW = MW + QBITS + 1;
  localparam int unsigned NST = 8;
  localparam int unsigned P = NST + QBITS + 1;

  logic [P-1:0] vld_q;
  logic [P-1:0] en;

  always_comb begin
    en[P-1] = !vld_q[P-1] || m_axis_tready;
    for (int k = P - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < P; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[P-1];

  logic signed [CW-1:0] p1_q [NST-3][3];
  logic signed [UW-1:0] du_q [3][3];
  logic signed [UW-1:0] dv_q [3][3];
  logic signed [NW-1:0] pa_q [3];
  logic signed [NW-1:0] pb_q [3];
  logic signed [NW-1:0] su_q [3];
  logic signed [NW-1:0] sv_q [3];
  logic signed [NW-1:0] n_q  [3];
  logic signed [NW-1:0] uu_q [3];
  logic signed [NW-1:0] vv_q [3];
  logic signed [DW-1:0] nn_q [3];
  logic signed [XW-1:0] ta_q [3];
  logic signed [XW-1:0] tb_q [3];
  logic signed [XW-1:0] tc_q [3];
  logic signed [XW-1:0] td_q [3];
  logic signed [DW-1:0] den_q [3];
  logic signed [XW-1:0] vxn_q [3];
  logic signed [XW-1:0] nxu_q [3];
  logic signed [MW-1:0] mal_q [3];
  logic signed [MW-1:0] mah_q [3];
  logic signed [MW-1:0] mbl_q [3];
  logic signed [MW-1:0] mbh_q [3];
  logic signed [MW-1:0] mcl_q [3];
  logic signed [MW-1:0] mch_q [3];
  logic signed [MW-1:0] num_q [3];
  logic [RW-1:0]        rem_q [3];
  logic [DW-1:0]        dd_q;
  side_t                side_q [QBITS+1];
  side_t                side_d;

  logic signed [CW-1:0] crd [9];
  logic signed [DW-1:0] den_sum;
  logic [RW-1:0]        rem_d [3];
  logic [QBITS-1:0]     quo [3];
  logic [QBITS-1:0]     cen_d [3];
  logic [QBITS-1:0]     cen_q [3];
  logic                 ovf_d;
  logic                 ovf_q;
  logic                 dgn_q;

  for (genvar j = 0; j < 9; j++) begin : g_crd
    assign crd[j] = $signed(s_axis_tdata[j*CW +: CW]);
  end

  assign den_sum = nn_q[0] + nn_q[1] + nn_q[2];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (en[0]) begin
        p1_q[0][k] <= crd[k];
        du_q[0][k] <= UW'(crd[3+k]) - UW'(crd[k]);
        dv_q[0][k] <= UW'(crd[6+k]) - UW'(crd[k]);
      end
      for (int s = 1; s < NST - 3; s++) begin
        if (en[s]) begin
          p1_q[s][k] <= p1_q[s-1][k];
        end
      end
      if (en[1]) begin
        du_q[1][k] <= du_q[0][k];
        dv_q[1][k] <= dv_q[0][k];
        su_q[k]    <= NW'(du_q[0][k]) * NW'(du_q[0][k]);
        sv_q[k]    <= NW'(dv_q[0][k]) * NW'(dv_q[0][k]);
      end
      if (en[2]) begin
        du_q[2][k] <= du_q[1][k];
        dv_q[2][k] <= dv_q[1][k];
        n_q[k]     <= pa_q[k] - pb_q[k];
      end
      if (en[3]) begin
        nn_q[k]    <= DW'(n_q[k]) * DW'(n_q[k]);
      end
      if (en[4]) begin
        vxn_q[k]   <= ta_q[k] - tb_q[k];
        nxu_q[k]   <= tc_q[k] - td_q[k];
      end
    end
    if (en[2]) begin
      uu_q[0] <= su_q[0] + su_q[1] + su_q[2];
      vv_q[0] <= sv_q[0] + sv_q[1] + sv_q[2];
    end
    if (en[3]) begin
      uu_q[1] <= uu_q[0];
      vv_q[1] <= vv_q[0];
    end
    if (en[4]) begin
      uu_q[2]  <= uu_q[1];
      vv_q[2]  <= vv_q[1];
      den_q[0] <= den_sum <<< 1;
    end
    if (en[5]) begin
      den_q[1] <= den_q[0];
    end
    if (en[6]) begin
      den_q[2] <= den_q[1];
    end
    if (en[NST-1]) begin
      dd_q      <= $unsigned(den_q[2]);
      side_q[0] <= side_d;
    end
    for (int s = 1; s <= QBITS; s++) begin
      if (en[NST-1+s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
    if (en[P-1]) begin
      for (int k = 0; k < 3; k++) begin
        cen_q[k] <= cen_d[k];
      end
      ovf_q <= ovf_d;
      dgn_q <= side_q[QBITS].degen;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int unsigned A = (k + 1) % 3;
    localparam int unsigned B = (k + 2) % 3;

    logic [MW-1:0]        mag;
    logic [LW-1:0]        lim;

    always_ff @(posedge clk_i) begin
      if (en[1]) begin
        pa_q[k] <= NW'(du_q[0][A]) * NW'(dv_q[0][B]);
        pb_q[k] <= NW'(du_q[0][B]) * NW'(dv_q[0][A]);
      end
      if (en[3]) begin
        ta_q[k] <= XW'(dv_q[2][A]) * XW'(n_q[B]);
        tb_q[k] <= XW'(dv_q[2][B]) * XW'(n_q[A]);
        tc_q[k] <= XW'(n_q[A]) * XW'(du_q[2][B]);
        td_q[k] <= XW'(n_q[B]) * XW'(du_q[2][A]);
      end
      if (en[5]) begin
        mal_q[k] <= MW'(uu_q[2]) * MW'($signed({1'b0, vxn_q[k][HX-1:0]}));
        mah_q[k] <= MW'(uu_q[2]) * MW'($signed(vxn_q[k][XW-1:HX]));
        mbl_q[k] <= MW'(vv_q[2]) * MW'($signed({1'b0, nxu_q[k][HX-1:0]}));
        mbh_q[k] <= MW'(vv_q[2]) * MW'($signed(nxu_q[k][XW-1:HX]));
        mcl_q[k] <= MW'(p1_q[4][k]) * MW'($signed({1'b0, den_q[0][HD-1:0]}));
        mch_q[k] <= MW'(p1_q[4][k]) * MW'($signed({1'b0, den_q[0][DW-1:HD]}));
      end
      if (en[6]) begin
        num_q[k] <= mal_q[k] + (mah_q[k] <<< HX) + mbl_q[k] + (mbh_q[k] <<< HX)
                  + mcl_q[k] + (mch_q[k] <<< HD);
      end
      if (en[NST-1]) begin
        rem_q[k] <= rem_d[k];
      end
    end

    assign mag = num_q[k][MW-1] ? MW'(-num_q[k]) : MW'(num_q[k]);
    assign lim = LW'($unsigned(den_q[2])) << QBITS;
    assign side_d.neg[k] = num_q[k][MW-1];
    assign side_d.big[k] = LW'(mag) >= lim;
    assign rem_d[k] = mag[RW-1:0];

    cc3d_div #(
      .RW (RW),
      .DW (DW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[NST+QBITS-1:NST]),
      .rem_i (rem_q[k]),
      .den_i (dd_q),
      .quo_o (quo[k])
    );
  end

  assign side_d.degen = (den_q[2] == '0);

  always_comb begin
    ovf_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (side_q[QBITS].degen) begin
        cen_d[k] = '0;
      end else if (!side_q[QBITS].neg[k]) begin
        if (side_q[QBITS].big[k] || quo[k][QBITS-1]) begin
          cen_d[k] = SAT_POS;
          ovf_d = 1'b1;
        end else begin
          cen_d[k] = quo[k];
        end
      end else begin
        if (side_q[QBITS].big[k] || (quo[k] > SAT_NEG)) begin
          cen_d[k] = SAT_NEG;
          ovf_d = 1'b1;
        end else begin
          cen_d[k] = -quo[k];
        end
      end
    end
  end

  assign m_axis_tdata = {cen_q[2], cen_q[1], cen_q[0]};
  assign m_axis_tuser = {ovf_q, dgn_q};

endmodule

// ===== rtl/core/cc3d_checker.sv =====
// ----------------------------------------------------------------------------
// cc3d_checker
// Port-level checks of the circumcentre pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cc3d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic sat_x;
  logic sat_y;
  logic sat_z;

  assign sat_x = (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000);
  assign sat_y = (m_axis_tdata[63:32] == 32'h7FFF_FFFF) || (m_axis_tdata[63:32] == 32'h8000_0000);
  assign sat_z = (m_axis_tdata[95:64] == 32'h7FFF_FFFF) || (m_axis_tdata[95:64] == 32'h8000_0000);

  `CC_ASSERT(a_degen_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
  `CC_ASSERT(a_ovf_sat, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> sat_x || sat_y || sat_z)
  `CC_ASSERT(a_ready_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `CC_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `CC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid || rst_ni)

endmodule

bind circumcenter_3d_points cc3d_checker u_cc3d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_circumcenter_3d_points.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circumcenter_3d_points
// Self-checking bench for the 3D circumcentre pipeline. A scoreboard works
// out each centre exactly in 256-bit integers and checks every output item
// in order. Stimulus covers directed corner triples and random triples.
// The random triples are a mix of free, collinear, coincident, near-collinear
// and small-range points. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_circumcenter_3d_points;
  import cc3d_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned DW = ((9*CB+7)/8)*8;
  localparam int unsigned LIMIT = 400000;
  localparam int unsigned DRAIN = 60;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CB-1:0] crd_t;

  typedef struct {
    logic [QBITS-1:0] cx, cy, cz;
    logic             degen, ovf;
  } centre_t;

  class centre_board;
    centre_t     due[$];
    int unsigned bad = 0;
    int unsigned seen = 0;
    int unsigned degen_seen = 0;
    int unsigned ovf_seen = 0;

    function logic [QBITS-1:0] clamp(wide_t q, ref logic ovf);
      wide_t qmax, qmin;
      qmax = 2147483647;
      qmin = -qmax - 1;
      if (q > qmax) begin
        ovf = 1'b1;
        return SAT_POS;
      end
      if (q < qmin) begin
        ovf = 1'b1;
        return SAT_NEG;
      end
      return q[QBITS-1:0];
    endfunction

    function void note(logic [DW-1:0] d);
      wide_t   p1[3], u[3], v[3], n[3];
      wide_t   uu, vv, den, num;
      crd_t    c;
      centre_t e;
      logic [QBITS-1:0] r[3];
      int a, b;
      for (int k = 0; k < 3; k++) begin
        c = d[k*CB +: CB];
        p1[k] = c;
        c = d[(3+k)*CB +: CB];
        u[k] = wide_t'(c) - p1[k];
        c = d[(6+k)*CB +: CB];
        v[k] = wide_t'(c) - p1[k];
      end
      n[0] = u[1]*v[2] - u[2]*v[1];
      n[1] = u[2]*v[0] - u[0]*v[2];
      n[2] = u[0]*v[1] - u[1]*v[0];
      uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      den = 2 * (n[0]*n[0] + n[1]*n[1] + n[2]*n[2]);
      e.ovf = 1'b0;
      if (den == 0) begin
        e.cx = '0; e.cy = '0; e.cz = '0; e.degen = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) begin
          a = (k + 1) % 3;
          b = (k + 2) % 3;
          num = uu * (v[a]*n[b] - v[b]*n[a]) + vv * (n[a]*u[b] - n[b]*u[a])
              + p1[k] * den;
          r[k] = clamp(num / den, e.ovf);
        end
        e.cx = r[0]; e.cy = r[1]; e.cz = r[2]; e.degen = 1'b0;
      end
      due = {due, e};
    endfunction

    function void check(logic [3*QBITS-1:0] d, logic [1:0] f);
      centre_t e;
      seen++;
      degen_seen += f[0];
      ovf_seen += f[1];
      if (due.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected centre item %h flags %b", d, f);
        return;
      end
      e = due.pop_front();
      if (d[0 +: QBITS] !== e.cx || d[QBITS +: QBITS] !== e.cy ||
          d[2*QBITS +: QBITS] !== e.cz || f[0] !== e.degen || f[1] !== e.ovf) begin
        bad++;
        if (bad <= 10)
          $display("item %0d: exp %h %h %h d%b o%b, got %h %h %h d%b o%b", seen,
                   e.cx, e.cy, e.cz, e.degen, e.ovf, d[0 +: QBITS],
                   d[QBITS +: QBITS], d[2*QBITS +: QBITS], f[0], f[1]);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DW-1:0]        s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [3*QBITS-1:0]   m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  centre_board board = new();

  circumcenter_3d_points #(.COORD_BITS(CB)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata, m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [DW-1:0] pack(int p[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*CB +: CB] = crd_t'(p[k]);
    return d;
  endfunction

  task automatic send(logic [DW-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_pts(int p[9]);
    send(pack(p));
  endtask

  function automatic int rc(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_random();
    int p[9];
    int dx, dy, dz, m;
    case ($urandom_range(9))
      0, 1, 2: begin
        send(DW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        return;
      end
      3: begin
        // collinear: third point on the line through the first two
        for (int k = 0; k < 3; k++) p[k] = rc(-10000, 10000);
        dx = rc(-100, 100); dy = rc(-100, 100); dz = rc(-100, 100);
        m = rc(-20, 20);
        p[3] = p[0] + dx; p[4] = p[1] + dy; p[5] = p[2] + dz;
        p[6] = p[0] + m*dx; p[7] = p[1] + m*dy; p[8] = p[2] + m*dz;
      end
      4: begin
        // coincident pair
        for (int k = 0; k < 6; k++) p[k] = rc(-32768, 32767);
        for (int k = 0; k < 3; k++) p[6+k] = p[$urandom_range(1)*3 + k];
      end
      5: begin
        // near-collinear, far-off centre
        dx = rc(-1000, 1000); dy = rc(-1000, 1000); dz = rc(-1000, 1000);
        for (int k = 0; k < 3; k++) p[k] = rc(-3000, 3000);
        m = rc(2, 30);
        p[3] = p[0] + m*dx; p[4] = p[1] + m*dy; p[5] = p[2] + m*dz;
        p[6] = p[0] + dx + rc(-1, 1); p[7] = p[1] + dy + rc(-1, 1);
        p[8] = p[2] + dz;
      end
      default: begin
        for (int k = 0; k < 9; k++) p[k] = rc(-64, 64);
      end
    endcase
    send_pts(p);
  endtask

  initial begin
    int p[9];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 36;
    recv_idle = 68;
    p = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_pts(p);
    p = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_pts(p);
    p = '{-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0};
    send_pts(p);
    p = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0};
    send_pts(p);
    p = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767};
    send_pts(p);
    p = '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 32767};
    send_pts(p);
    p = '{1, 2, 3, 1, 2, 3, 7, -5, 9};
    send_pts(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_pts(p);
    p = '{10, 0, 0, 0, 10, 0, 0, 0, 10};
    send_pts(p);
    p = '{-32768, 0, 0, 32767, 2, 0, 0, 1, 0};
    send_pts(p);
    p = '{-32768, 0, 0, 32767, -2, 0, 0, -1, 0};
    send_pts(p);
    p = '{0, -32768, 0, 2, 32767, 0, 1, 0, 5};
    send_pts(p);
    p = '{-32768, -32768, 0, 32767, 32767, 0, 0, 1, 0};
    send_pts(p);
    p = '{-1, -1, -1, 1, 1, 1, 3, 3, 3};
    send_pts(p);
    p = '{5, 5, 5, -3, 4, 8, 100, -200, 300};
    send_pts(p);

    send_idle = 36; recv_idle = 68;
    repeat (283) send_random();
    send_idle = 68; recv_idle = 36;
    repeat (283) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (284) send_random();
    s_axis_tvalid <= 1'b0;

    while (board.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("sent %0d triples, checked %0d centres", sent, board.seen);
    $display("degenerate %0d, saturated %0d, mismatches %0d",
             board.degen_seen, board.ovf_seen, board.bad);
    if (board.bad == 0 && board.due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== circumcenter_3d_points.f =====
+incdir+rtl/core
rtl/core/cc3d_pkg.sv
rtl/core/cc3d_div.sv
rtl/core/circumcenter_3d_points.sv
rtl/core/cc3d_checker.sv
sim/tb_circumcenter_3d_points.sv
